// File: hw/rtl/c_comment_stripper_unit_defines.svh
// Assertion macros for the comment stripper.
// Included by the module that checks its own logic; no other dependencies.
`ifndef C_COMMENT_STRIPPER_UNIT_DEFINES_SVH
`define C_COMMENT_STRIPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside of reset.
`define CCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define CCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/ccs_pkg.sv
// Types and character constants for the comment stripper.
// No dependencies.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [5:0] {
        M_NORMAL     = 6'b000001,
        M_SLASH      = 6'b000010,
        M_STRING     = 6'b000100,
        M_LINE       = 6'b001000,
        M_BLOCK      = 6'b010000,
        M_BLOCK_STAR = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eot;
        logic       unc;
    } t_result;

endpackage

// File: hw/rtl/c_comment_stripper_unit.sv
// C-style comment stripper: byte stream in, comment-free byte stream out.
// Depends on ccs_pkg and c_comment_stripper_unit_defines.svh.
//
// Takes one text byte per cycle through an input register and gives the
// bytes with comments removed. One item is accepted every cycle as long
// as the output side keeps up. Each input item yields one or two output
// items, or none; a final byte always yields at least one, marked by tlast.
// A held '/' released together with the following byte yields two output
// items, so the output drains one item per cycle, while the receiver is ready,
// from a two-entry queue and the input pauses when that queue cannot take both.
// tuser bit 0 says whether tdata carries a character; tuser bit 1 on the
// last item flags text that ended inside a block comment.
`include "c_comment_stripper_unit_defines.svh"

module c_comment_stripper_unit
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // end_of_text
    output logic [1:0] m_axis_tuser    // [0] has_byte, [1] unclosed_block
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    t_mode      r_mode, n_mode;

    // output queue, head at r_q0
    t_result    r_q0, n_q0;
    t_result    r_q1, n_q1;
    logic [1:0] r_cnt, n_cnt;

    logic       w_accept;
    logic       w_pop;
    logic [1:0] w_cnt_ap;
    logic       w_proc;
    logic [1:0] w_nres;
    t_result    w_res0, w_res1;

    // per-item decode
    logic       w_nb_emit;
    t_mode      w_nb_mode;
    logic       w_e0, w_e1, w_te, w_unc;
    logic [7:0] w_b0, w_b1, w_tb;
    t_mode      w_mode_ns;
    logic [1:0] w_raw;
    logic [2:0] w_need;

    // normal-mode handling of the current byte
    always_comb begin
        w_nb_emit = 1'b1;
        w_nb_mode = M_NORMAL;
        if (r_in_byte == CH_QUOTE) begin
            w_nb_mode = M_STRING;
        end else if (r_in_byte == CH_SLASH) begin
            w_nb_emit = 1'b0;
            w_nb_mode = M_SLASH;
        end
    end

    always_comb begin
        w_mode_ns = r_mode;
        w_e0      = 1'b0;
        w_e1      = 1'b0;
        w_b0      = r_in_byte;
        w_b1      = r_in_byte;
        unique case (r_mode)
            M_SLASH: begin
                if (r_in_byte == CH_SLASH) begin
                    w_mode_ns = M_LINE;
                end else if (r_in_byte == CH_STAR) begin
                    w_mode_ns = M_BLOCK;
                end else begin
                    // release the held slash, then the byte as in normal mode
                    w_e0      = 1'b1;
                    w_b0      = CH_SLASH;
                    w_e1      = w_nb_emit;
                    w_mode_ns = w_nb_mode;
                end
            end
            M_STRING: begin
                w_e0 = 1'b1;
                if (r_in_byte == CH_QUOTE) begin
                    w_mode_ns = M_NORMAL;
                end
            end
            M_LINE: begin
                if (r_in_byte == CH_NL) begin
                    w_e0      = 1'b1;
                    w_mode_ns = M_NORMAL;
                end
            end
            M_BLOCK: begin
                if (r_in_byte == CH_STAR) begin
                    w_mode_ns = M_BLOCK_STAR;
                end else if (r_in_byte == CH_NL) begin
                    w_e0 = 1'b1;
                end
            end
            M_BLOCK_STAR: begin
                if (r_in_byte == CH_SLASH) begin
                    w_mode_ns = M_NORMAL;
                end else if (r_in_byte != CH_STAR) begin
                    w_e0      = (r_in_byte == CH_NL);
                    w_mode_ns = M_BLOCK;
                end
            end
            default: begin
                w_e0      = w_nb_emit;
                w_mode_ns = w_nb_mode;
            end
        endcase

        // end of text: flush what the mode still holds
        w_te  = 1'b0;
        w_tb  = 8'h00;
        w_unc = 1'b0;
        if (r_in_last) begin
            if (w_mode_ns == M_SLASH) begin
                w_te = 1'b1;
                w_tb = CH_SLASH;
            end else if (w_mode_ns == M_LINE) begin
                w_te = 1'b1;
                w_tb = CH_NL;
            end else if (w_mode_ns == M_BLOCK || w_mode_ns == M_BLOCK_STAR) begin
                w_unc = 1'b1;
            end
        end
        n_mode = r_in_last ? M_NORMAL : w_mode_ns;

        if (w_e0) begin
            w_raw = (w_e1 || w_te) ? 2'd2 : 2'd1;
        end else begin
            w_raw = w_te ? 2'd1 : 2'd0;
        end
        w_nres = (r_in_last && w_raw == 2'd0) ? 2'd1 : w_raw;

        w_res0.data = w_e0 ? w_b0 : w_tb;
        w_res0.has  = w_e0 || w_te;
        w_res0.eot  = r_in_last && (w_nres == 2'd1);
        w_res0.unc  = w_unc && (w_nres == 2'd1);
        w_res1.data = w_e1 ? w_b1 : w_tb;
        w_res1.has  = 1'b1;
        w_res1.eot  = r_in_last && (w_nres == 2'd2);
        w_res1.unc  = w_unc && (w_nres == 2'd2);
    end

    assign w_pop    = (r_cnt != 2'd0) && m_axis_tready;
    assign w_cnt_ap = r_cnt - {1'b0, w_pop};
    assign w_need   = {1'b0, w_cnt_ap} + {1'b0, w_nres};
    assign w_proc   = r_in_valid && (w_need <= 3'd2);

    assign s_axis_tready = !r_in_valid || w_proc;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_proc) begin
            n_in_valid = 1'b0;
        end

        // advance the queue, then append this item's results
        n_q0 = w_pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        n_cnt = w_cnt_ap;
        if (w_proc) begin
            n_cnt = w_need[1:0];
            if (w_cnt_ap == 2'd0) begin
                n_q0 = w_res0;
                n_q1 = w_res1;
            end else if (w_cnt_ap == 2'd1) begin
                n_q1 = w_res0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_NORMAL;
            r_cnt      <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            if (w_proc) begin
                r_mode <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q0.data;
    assign m_axis_tlast  = r_q0.eot;
    assign m_axis_tuser  = {r_q0.unc, r_q0.has};

    `CCS_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "output queue count out of range")
    `CCS_ASSERT(a_last_gives_result, i_clk, i_rst_n, (w_proc && r_in_last) |-> (w_nres != 2'd0), "final byte produced no item")
    `CCS_ASSERT(a_mode_after_end, i_clk, i_rst_n, (w_proc && r_in_last) |=> (r_mode == M_NORMAL), "mode not back to normal after end of text")
    `CCS_ASSERT(a_empty_is_end, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast, "empty item that is not the end item")
    `CCS_ASSERT(a_unc_on_end, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast, "unclosed flag away from end item")

endmodule

// File: bench/tb_c_comment_stripper_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for c_comment_stripper_unit: directed rows, then random C-like text.
// Depends on ccs_pkg; a local predictor of the stripper supplies the expected output items.
module tb_c_comment_stripper_unit;
    import ccs_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] text_byte
    logic       s_axis_tlast;   // final_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;   // end_of_text
    logic [1:0] m_axis_tuser;   // [0] has_byte, [1] unclosed_block

    t_mode      strip_mode = M_NORMAL;
    t_result    clean_q[$];
    t_result    step_res[$];
    t_result    head;
    logic [7:0] text_q[$];
    t_dir_row   dir_rows[26];
    int         fail_cnt = 0;
    int         burst_left = 0;
    int         item_cnt;
    int         hold_left = 0;
    int         pat_cnt = 0;
    bit         hold_req = 1'b0;
    bit         mid_done = 1'b0;

    c_comment_stripper_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void put_char(ref t_result res[$], input logic [7:0] b);
        res.push_back('{data: b, has: 1'b1, eot: 1'b0, unc: 1'b0});
    endfunction

    function automatic void code_char(ref t_result res[$], input logic [7:0] c);
        if (c == CH_QUOTE) begin
            put_char(res, c);
            strip_mode = M_STRING;
        end else if (c == CH_SLASH) begin
            strip_mode = M_SLASH;
        end else begin
            put_char(res, c);
            strip_mode = M_NORMAL;
        end
    endfunction

    function automatic void strip_step(input logic [7:0] c, input logic fin,
                                       ref t_result res[$]);
        logic unc;
        unc = 1'b0;
        res.delete();
        case (strip_mode)
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    strip_mode = M_LINE;
                end else if (c == CH_STAR) begin
                    strip_mode = M_BLOCK;
                end else begin
                    // release the held slash ahead of this byte
                    put_char(res, CH_SLASH);
                    code_char(res, c);
                end
            end
            M_STRING: begin
                put_char(res, c);
                if (c == CH_QUOTE) strip_mode = M_NORMAL;
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    put_char(res, CH_NL);
                    strip_mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR) strip_mode = M_BLOCK_STAR;
                else if (c == CH_NL) put_char(res, CH_NL);
            end
            M_BLOCK_STAR: begin
                if (c == CH_SLASH) begin
                    strip_mode = M_NORMAL;
                end else if (c != CH_STAR) begin
                    if (c == CH_NL) put_char(res, CH_NL);
                    strip_mode = M_BLOCK;
                end
            end
            default: code_char(res, c);
        endcase
        if (fin) begin
            case (strip_mode)
                M_SLASH:              put_char(res, CH_SLASH);
                M_LINE:               put_char(res, CH_NL);
                M_BLOCK, M_BLOCK_STAR: unc = 1'b1;
                default: ;
            endcase
            if (res.size() == 0) res.push_back('0);
            res[res.size()-1].eot = 1'b1;
            res[res.size()-1].unc = unc;
            strip_mode = M_NORMAL;
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return CH_SLASH;
        if (r < 5) return CH_STAR;
        if (r < 7) return CH_NL;
        if (r == 7) return CH_QUOTE;
        if (r == 8) return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // Build one text from comment, string and plain tokens, cut at a random length
    // so that some texts end inside a construct.
    task automatic gen_text();
        int len;
        int k;
        text_q.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
        while (text_q.size() < len) begin
            k = $urandom_range(0, 6);
            case ($urandom_range(0, 5))
                0: begin
                    text_q.push_back(CH_SLASH);
                    text_q.push_back(CH_SLASH);
                    repeat (k) text_q.push_back(pick_char());
                    text_q.push_back(CH_NL);
                end
                1: begin
                    text_q.push_back(CH_SLASH);
                    text_q.push_back(CH_STAR);
                    repeat (k) text_q.push_back(pick_char());
                    text_q.push_back(CH_STAR);
                    text_q.push_back(CH_SLASH);
                end
                2: begin
                    text_q.push_back(CH_QUOTE);
                    repeat (k) text_q.push_back(pick_char());
                    text_q.push_back(CH_QUOTE);
                end
                default: text_q.push_back(pick_char());
            endcase
        end
        while (text_q.size() > len) void'(text_q.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                             input t_result want);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 8)) begin
                    @(negedge i_clk);
                    s_axis_tvalid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        strip_step(b, fin, step_res);
        if (typed) clean_q.push_back(want);
        else foreach (step_res[i]) clean_q.push_back(step_res[i]);
    endtask

    // Stop offering and wait until every expected item is out.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (clean_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (clean_q.size() == 0) begin
                note_fail($sformatf("unexpected item data=%h has=%b eot=%b unc=%b",
                    m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]));
            end else begin
                head = clean_q.pop_front();
                if (m_axis_tdata !== head.data || m_axis_tuser[0] !== head.has ||
                    m_axis_tlast !== head.eot || m_axis_tuser[1] !== head.unc)
                    note_fail($sformatf(
                        "mismatch exp data=%h has=%b eot=%b unc=%b got data=%h has=%b eot=%b unc=%b",
                        head.data, head.has, head.eot, head.unc, m_axis_tdata,
                        m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]));
            end
        end
    end

    // Receiver: phases of full rate, random and periodic stalls, plus a long hold-off on request.
    initial begin
        int kind;
        m_axis_tready = 1'b0;
        forever begin
            kind = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60)) begin
                @(negedge i_clk);
                pat_cnt++;
                if (hold_req) begin
                    hold_req  = 1'b0;
                    hold_left = 300;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    case (kind)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= (pat_cnt % 3 == 0);
                        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[c_comment_stripper_unit] ERROR");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        dir_rows = '{
            '{8'h61,    1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
            '{8'h00,    1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
            '{8'hFF,    1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
            // held slash followed by a plain byte
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{8'h78,    1'b0, 1'b0, '0},
            // comment marks inside a string stay
            '{CH_QUOTE, 1'b0, 1'b0, '0},
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{CH_STAR,  1'b0, 1'b0, '0},
            '{CH_QUOTE, 1'b0, 1'b0, '0},
            // line comment closed by newline
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{8'h7A,    1'b0, 1'b0, '0},
            '{CH_NL,    1'b0, 1'b0, '0},
            // block comment with star-newline, star-star and close
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{CH_STAR,  1'b0, 1'b0, '0},
            '{CH_STAR,  1'b0, 1'b0, '0},
            '{CH_NL,    1'b0, 1'b0, '0},
            '{CH_STAR,  1'b0, 1'b0, '0},
            '{CH_STAR,  1'b0, 1'b0, '0},
            '{CH_SLASH, 1'b0, 1'b0, '0},
            // slash on the final byte
            '{CH_SLASH, 1'b1, 1'b0, '0},
            // line comment running to the end
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{CH_SLASH, 1'b1, 1'b1, '{CH_NL, 1'b1, 1'b1, 1'b0}},
            // end right after the block opening: nothing to emit, unclosed flagged
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{CH_STAR,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
            // string left open at the end
            '{CH_QUOTE, 1'b1, 1'b1, '{CH_QUOTE, 1'b1, 1'b1, 1'b0}}
        };
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // stall the output for a long stretch while texts keep coming
        hold_req = 1'b1;
        item_cnt = 0;
        while (item_cnt < 1400) begin
            gen_text();
            if (!mid_done && item_cnt >= 700) begin
                drain();
                mid_done = 1'b1;
            end
            foreach (text_q[i]) begin
                send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
                item_cnt++;
            end
        end
        drain();

        if (fail_cnt == 0) begin
            $display("[c_comment_stripper_unit] OK");
        end else begin
            $display("[c_comment_stripper_unit] ERROR");
        end
        $finish;
    end

endmodule
